>>> hw/rtl/upi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// upi_pkg: shared types and constants of the unicycle pose integrator
// CORDIC table, register indexes, the multiplier opcode set and request type.
// ----------------------------------------------------------------------------
package upi_pkg;

	localparam int CordicIters = 16;

	// Register indexes of the configuration port.
	typedef enum logic [2:0] {
		REG_GOAL_A   = 3'd0,
		REG_GOAL_B   = 3'd1,
		REG_GOAL_C   = 3'd2,
		REG_OBST_C   = 3'd3,
		REG_OBST_R   = 3'd4,
		REG_GOAL_R   = 3'd5,
		REG_STEP     = 3'd6,
		REG_NONE     = 3'd7
	} reg_idx_t;

	// Operations of the shared multiplier unit.
	typedef enum logic [1:0] {
		MUL_A_B  = 2'd0,
		MUL_ACC  = 2'd1,
		MUL_SQ   = 2'd2,
		MUL_IDLE = 2'd3
	} mul_op_t;

	// Request from the sequencer to the multiplier.
	typedef struct packed {
		logic          start;
		logic signed [33:0] a;
		logic signed [33:0] b;
		logic          acc;
	} mul_req_t;

	// Arctangent table in Q0.32 turns, scaled to 2^32 per turn.
	function automatic logic [31:0] atan_lut(input logic [3:0] i);
		logic [31:0] r;
		begin
			case (i)
				4'd0:  r = 32'h20000000;
				4'd1:  r = 32'h12E4051E;
				4'd2:  r = 32'h09FB385B;
				4'd3:  r = 32'h051111D4;
				4'd4:  r = 32'h028B0D43;
				4'd5:  r = 32'h0145D7E1;
				4'd6:  r = 32'h00A2F61E;
				4'd7:  r = 32'h00517C55;
				4'd8:  r = 32'h0028BE53;
				4'd9:  r = 32'h00145F2F;
				4'd10: r = 32'h000A2F98;
				4'd11: r = 32'h000517CC;
				4'd12: r = 32'h00028BE6;
				4'd13: r = 32'h000145F3;
				4'd14: r = 32'h0000A2FA;
				default: r = 32'h0000517D;
			endcase
			return r;
		end
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/upi_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// upi_cordic: iterative CORDIC rotation
// One shift-add rotation per cycle, sixteen rotations for cosine and sine.
// ----------------------------------------------------------------------------
module upi_cordic (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [15:0]        heading,
	output logic                    done,
	output logic signed [31:0]      cos_o,
	output logic signed [31:0]      sin_o
);

	logic signed [33:0] x_q, y_q, z_q;
	logic               flip_q, busy_q;
	logic [3:0]         it_q;
	logic signed [33:0] z0, xs, ys, at;

	// Start angle, arctangent step and shifted terms of the rotation.
	always_comb begin
		z0 = 34'(signed'({heading, 16'h0000}));
		at = 34'(signed'({2'b00, upi_pkg::atan_lut(it_q)}));
		xs = x_q >>> it_q;
		ys = y_q >>> it_q;
	end

	// Start angle folding and rotation loop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			it_q   <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				it_q   <= '0;
				x_q    <= 34'sh26DD3B6A;
				y_q    <= '0;
				if (z0 > 34'sh40000000) begin
					z_q <= z0 - 34'sh80000000;
					flip_q <= 1'b1;
				end else if (z0 < -34'sh40000000) begin
					z_q <= z0 + 34'sh80000000;
					flip_q <= 1'b1;
				end else begin
					z_q <= z0;
					flip_q <= 1'b0;
				end
			end else if (busy_q) begin
				if (!z_q[33]) begin
					x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - at;
				end else begin
					x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + at;
				end
				it_q <= it_q + 4'd1;
				if (it_q == 4'(upi_pkg::CordicIters - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign cos_o = flip_q ? -x_q[31:0] : x_q[31:0];
	assign sin_o = flip_q ? -y_q[31:0] : y_q[31:0];

endmodule
`default_nettype wire

>>> hw/rtl/upi_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// upi_isqrt: bit-pair integer square root
// One result bit per bit pair, 32 result bits for a 64-bit radicand; a start while busy restarts.
// ----------------------------------------------------------------------------
module upi_isqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] value,
	output logic             done,
	output logic [31:0]      root
);

	logic [63:0] v_q, res_q, bit_q;
	logic        busy_q;
	logic [64:0] trial;

	always_comb trial = {1'b0, res_q} + {1'b0, bit_q};

	// Restoring root recurrence, one bit pair per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				v_q    <= value;
				res_q  <= '0;
				bit_q  <= 64'h4000_0000_0000_0000;
			end else if (busy_q) begin
				if ({1'b0, v_q} >= trial) begin
					v_q   <= v_q - trial[63:0];
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (bit_q[0]) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign root = res_q[31:0];

endmodule
`default_nettype wire

>>> hw/rtl/upi_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// upi_mul: shared registered multiplier
// One signed 34 x 34 product per request, with optional accumulate.
// ----------------------------------------------------------------------------
module upi_mul (
	input  wire logic              clk,
	input  wire upi_pkg::mul_req_t req,
	output logic signed [67:0]     prod_q,
	output logic signed [67:0]     acc_q
);

	logic signed [67:0] p;

	always_comb p = req.a * req.b;

	// Product register, and a running sum for squared distances.
	always_ff @(posedge clk) begin
		if (req.start) begin
			prod_q <= p;
			acc_q  <= req.acc ? acc_q + p : p;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/unicycle_pose_integrator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// unicycle_pose_integrator: dead-reckoning odometry with goal cycling
// Integrates unicycle kinematics, flags obstacle proximity, cycles goals.
// ----------------------------------------------------------------------------
//  channel | direction | handshake
//  in      | input     | in_valid / in_ready
//  out     | output    | out_valid / out_ready
//  cfg     | input     | cfg_valid / cfg_ready, cfg_index, cfg_data
//
// A result beat follows its input beat after 16 CORDIC rotations, a sequence of
// products on the one shared multiplier and 32 square root steps. A reached
// goal repeats S_GO1, S_GO2 and S_CHK for the second distance. Input is
// ready again the cycle after the result beat is taken.
// Input is not ready while a tick is in work or its result waits.
// Reset clears pose, commands, goal index and counter, and loads defaults.
// ----------------------------------------------------------------------------
module unicycle_pose_integrator #(
	parameter int NUM_GOALS = 3
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        cmd_present,
	input  wire logic        link_lost,
	input  wire logic signed [15:0] lin_vel,
	input  wire logic signed [15:0] ang_vel,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [15:0] heading_angle,
	output logic signed [15:0] lin_vel_used,
	output logic signed [15:0] ang_vel_used,
	output logic signed [15:0] target_x,
	output logic signed [15:0] target_y,
	output logic [15:0]      target_dist,
	output logic             reached,
	output logic             collision,
	output logic [31:0]      tick_count,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_CORD, S_MX1, S_MX2, S_MY1, S_MY2, S_MH1, S_MH2,
		S_UPD, S_OB1, S_OB2, S_GO1, S_GO2, S_CHK, S_SQRT, S_OUT
	} state_t;

	state_t state_q;
	logic [31:0] goal_a_q, goal_b_q, goal_c_q, obst_c_q;
	logic [15:0] obst_r_q, goal_r_q, step_q;
	logic [31:0] x_q, y_q, tick_q;
	logic [15:0] head_q, lin_q, ang_q;
	logic [1:0]  gidx_q;
	logic        reached_q, coll_q, cstart, cdone, sstart, sdone, second_q;
	logic signed [31:0] cos_w, sin_w;
	logic [31:0] root_w;
	logic [63:0] sq_in_q;
	upi_pkg::mul_req_t req;
	logic signed [67:0] prod_w, acc_w;
	logic [31:0] gpt, pt;
	logic signed [33:0] dx, dy;
	logic [63:0] rad_o, rad_g;
	logic [1:0]  gnext;

	upi_cordic u_cordic (.clk, .arst_n, .start(cstart), .heading(head_q),
		.done(cdone), .cos_o(cos_w), .sin_o(sin_w));
	upi_isqrt u_isqrt (.clk, .arst_n, .start(sstart), .value(sq_in_q),
		.done(sdone), .root(root_w));
	upi_mul u_mul (.clk, .req, .prod_q(prod_w), .acc_q(acc_w));

	// Goal selection; index three reads as the first goal.
	function automatic logic [31:0] goal_sel(input logic [1:0] i, input logic [31:0] a,
		input logic [31:0] b, input logic [31:0] c);
		logic [31:0] r;
		begin
			case (i)
				2'd1: r = b;
				2'd2: r = c;
				default: r = a;
			endcase
			return r;
		end
	endfunction

	// Operand selection for the shared multiplier and distance terms.
	always_comb begin
		gpt = goal_sel(gidx_q, goal_a_q, goal_b_q, goal_c_q);
		pt  = (state_q == S_OB1 || state_q == S_OB2) ? obst_c_q : gpt;
		dx  = (34'(signed'(x_q)) - 34'(signed'({pt[31:16], 16'h0})) ) >>> 8;
		dy  = (34'(signed'(y_q)) - 34'(signed'({pt[15:0], 16'h0})) ) >>> 8;
		rad_o = {40'h0, obst_r_q, 8'h0} * {40'h0, obst_r_q, 8'h0};
		rad_g = {40'h0, goal_r_q, 8'h0} * {40'h0, goal_r_q, 8'h0};
		gnext = (32'(gidx_q) + 32'd1 >= 32'(NUM_GOALS)) ? 2'd0 : gidx_q + 2'd1;
		req = '{start: 1'b0, a: '0, b: '0, acc: 1'b0};
		unique case (state_q)
			S_MX1: req = '{1'b1, 34'(signed'(lin_q)), 34'(signed'({1'b0, step_q})), 1'b0};
			S_MX2: req = '{1'b1, prod_w[33:0], 34'(cos_w), 1'b0};
			S_MY1: req = '{1'b1, 34'(signed'(lin_q)), 34'(signed'({1'b0, step_q})), 1'b0};
			S_MY2: req = '{1'b1, prod_w[33:0], 34'(sin_w), 1'b0};
			S_MH1: req = '{1'b1, 34'(signed'(ang_q)), 34'(signed'({1'b0, step_q})), 1'b0};
			S_MH2: req = '{1'b1, prod_w[33:0], 34'sd683565276, 1'b0};
			S_OB1, S_GO1: req = '{1'b1, dx, dx, 1'b0};
			S_OB2, S_GO2: req = '{1'b1, dy, dy, 1'b1};
			default: req = '{start: 1'b0, a: '0, b: '0, acc: 1'b0};
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign cstart = (state_q == S_IDLE) && in_valid;

	// Sequencer with registered results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			goal_a_q <= 32'd50332160; goal_b_q <= 32'd4261413248;
			goal_c_q <= 32'd16842112; obst_c_q <= 32'd25166080;
			obst_r_q <= 16'd90; goal_r_q <= 16'd51; step_q <= 16'd655;
			x_q <= '0; y_q <= '0; head_q <= '0; lin_q <= '0; ang_q <= '0;
			gidx_q <= '0; tick_q <= '0; out_valid <= 1'b0; sstart <= 1'b0;
			second_q <= 1'b0;
		end else begin
			sstart <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cfg_valid) begin
						unique case (upi_pkg::reg_idx_t'(cfg_index))
							upi_pkg::REG_GOAL_A: goal_a_q <= cfg_data;
							upi_pkg::REG_GOAL_B: goal_b_q <= cfg_data;
							upi_pkg::REG_GOAL_C: goal_c_q <= cfg_data;
							upi_pkg::REG_OBST_C: obst_c_q <= cfg_data;
							upi_pkg::REG_OBST_R: obst_r_q <= cfg_data[15:0];
							upi_pkg::REG_GOAL_R: goal_r_q <= cfg_data[15:0];
							upi_pkg::REG_STEP:   step_q <= cfg_data[15:0];
							default: ;
						endcase
					end
					if (in_valid) begin
						if (link_lost) begin
							lin_q <= '0; ang_q <= '0;
						end else if (cmd_present) begin
							lin_q <= lin_vel; ang_q <= ang_vel;
						end
						state_q <= S_CORD;
					end
				end
				S_CORD: if (cdone) state_q <= S_MX1;
				S_MX1: state_q <= S_MX2;
				S_MX2: state_q <= S_MY1;
				S_MY1: begin
					x_q <= x_q + 32'((prod_w + 68'sh200000000) >>> 34);
					state_q <= S_MY2;
				end
				S_MY2: state_q <= S_MH1;
				S_MH1: begin
					y_q <= y_q + 32'((prod_w + 68'sh200000000) >>> 34);
					state_q <= S_MH2;
				end
				S_MH2: state_q <= S_UPD;
				S_UPD: begin
					head_q <= head_q + 16'((prod_w + 68'sh80000000000) >>> 44);
					second_q <= 1'b0;
					state_q <= S_OB1;
				end
				S_OB1: state_q <= S_OB2;
				S_OB2: state_q <= S_GO1;
				S_GO1: begin
					if (!second_q) coll_q <= acc_w[63:0] < rad_o;
					state_q <= S_GO2;
				end
				S_GO2: state_q <= S_CHK;
				S_CHK: begin
					if (!second_q && acc_w[63:0] < rad_g) begin
						reached_q <= 1'b1;
						gidx_q <= gnext;
						second_q <= 1'b1;
						state_q <= S_GO1;
					end else begin
						if (!second_q) reached_q <= 1'b0;
						sq_in_q <= acc_w[63:0];
						sstart <= 1'b1;
						state_q <= S_SQRT;
					end
				end
				S_SQRT: if (sdone) begin
					target_dist <= (root_w[31:24] != 8'h0) ? 16'hFFFF : root_w[23:8];
					pos_x <= x_q; pos_y <= y_q; heading_angle <= head_q;
					lin_vel_used <= lin_q; ang_vel_used <= ang_q;
					target_x <= gpt[31:16]; target_y <= gpt[15:0];
					reached <= reached_q; collision <= coll_q;
					tick_count <= tick_q;
					tick_q <= tick_q + 32'd1;
					out_valid <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: if (out_ready) begin
					out_valid <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/upi_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// upi_checker: port-level checks of the pose integrator
// Watches the input and result handshakes and configuration readiness.
// ----------------------------------------------------------------------------
module upi_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic cfg_ready,
	input wire logic [31:0] tick_count
);

	// No input beat is taken while a result waits.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");

	// An accepted beat never yields a result in the next cycle.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !out_valid) else $error("result too early");

	// A waiting result holds its tick number.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(tick_count))
		else $error("tick count changed while stalled");

	// Configuration is taken only while idle for input.
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready == in_ready) else $error("config ready outside idle");

endmodule

bind unicycle_pose_integrator upi_checker u_upi_checker (.clk, .arst_n, .in_valid,
	.in_ready, .out_valid, .out_ready, .cfg_ready, .tick_count);
`default_nettype wire

>>> verif/tb_unicycle_pose_integrator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_unicycle_pose_integrator: self-checking bench of the pose integrator
// A queue-fed driver sends tick beats, and a clocked monitor compares every
// result beat with a pose predicted in the bench, across several register
// settings.
// ----------------------------------------------------------------------------
module tb_unicycle_pose_integrator;

	typedef struct {
		logic        cmd;
		logic        lost;
		logic [15:0] lin;
		logic [15:0] ang;
	} tick_t;

	typedef struct {
		logic [31:0] px;
		logic [31:0] py;
		logic [15:0] hd;
		logic [15:0] lu;
		logic [15:0] au;
		logic [15:0] tx;
		logic [15:0] ty;
		logic [15:0] td;
		logic        rch;
		logic        col;
		logic [31:0] tc;
	} pose_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic cmd_present = 1'b0;
	logic link_lost = 1'b0;
	logic signed [15:0] lin_vel = '0;
	logic signed [15:0] ang_vel = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] pos_x, pos_y;
	logic [15:0] heading_angle, lin_vel_used, ang_vel_used, target_x, target_y;
	logic [15:0] target_dist;
	logic reached, collision;
	logic [31:0] tick_count;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	upi_pkg::reg_idx_t cfg_index = upi_pkg::REG_GOAL_A;
	logic [31:0] cfg_data = '0;

	unicycle_pose_integrator uut (.*);

	always #5 clk = ~clk;

	// Bench copy of registers and pose state.
	logic [31:0] m_goal [3];
	logic [31:0] m_obst;
	logic [15:0] m_obst_r, m_goal_r, m_step;
	logic [31:0] m_x, m_y, m_ticks;
	logic [15:0] m_head, m_lin, m_ang;
	logic [1:0]  m_gidx;

	tick_t tick_q [$];
	pose_t pose_q [$];
	int errors = 0;
	bit running = 0;
	bit hold_send = 0;
	bit idle_en = 1;
	bit in_hs = 0;

	// Heading to cosine and sine by rotation, Q2.30.
	task automatic trig(input logic [15:0] h, output longint c, output longint s);
		longint z, x, y, t;
		bit flip;
		z = longint'($signed({h, 16'h0000}));
		x = 64'sh26DD3B6A;
		y = 0;
		flip = 0;
		if (z > 64'sh40000000) begin
			z -= 64'sh80000000; flip = 1;
		end else if (z < -64'sh40000000) begin
			z += 64'sh80000000; flip = 1;
		end
		for (int i = 0; i < 16; i++) begin
			if (z >= 0) begin
				t = x - (y >>> i); y = y + (x >>> i);
				z -= longint'(upi_pkg::atan_lut(i[3:0]));
			end else begin
				t = x + (y >>> i); y = y - (x >>> i);
				z += longint'(upi_pkg::atan_lut(i[3:0]));
			end
			x = t;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	function automatic longint rshift_round(longint v, int n);
		return (v + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	// Squared distance from the current position to a packed point, Q8 differences squared (Q.16).
	function automatic longint sq_dist_to(logic [31:0] p);
		longint dx, dy;
		dx = (longint'($signed(m_x)) - longint'($signed(p[31:16])) * 65536) >>> 8;
		dy = (longint'($signed(m_y)) - longint'($signed(p[15:0])) * 65536) >>> 8;
		return dx * dx + dy * dy;
	endfunction

	function automatic longint sq_radius(logic [15:0] r);
		longint q;
		q = longint'(r) << 8;
		return q * q;
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b; res = (res >> 1) + b;
			end else res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic [31:0] goal_at(logic [1:0] i);
		return (i == 2'd1) ? m_goal[1] : (i == 2'd2) ? m_goal[2] : m_goal[0];
	endfunction

	// Advances the bench pose by one tick and returns the expected result.
	task automatic integrate_tick(input tick_t t, output pose_t r);
		longint lin, ang, dt, c, s, dsq;
		logic [63:0] tgt_dist;
		logic [31:0] g;
		bit hit;
		if (t.cmd) begin
			m_lin = t.lin; m_ang = t.ang;
		end
		if (t.lost) begin
			m_lin = '0; m_ang = '0;
		end
		lin = longint'($signed(m_lin));
		ang = longint'($signed(m_ang));
		dt = longint'(m_step);
		trig(m_head, c, s);
		m_x = m_x + 32'(rshift_round(lin * c * dt, 34));
		m_y = m_y + 32'(rshift_round(lin * s * dt, 34));
		m_head = m_head + 16'(rshift_round(ang * dt * 64'sd683565276, 44));
		r.col = sq_dist_to(m_obst) < sq_radius(m_obst_r);
		dsq = sq_dist_to(goal_at(m_gidx));
		hit = dsq < sq_radius(m_goal_r);
		if (hit) begin
			m_gidx = (m_gidx + 2'd1 >= 2'd3) ? 2'd0 : m_gidx + 2'd1;
			dsq = sq_dist_to(goal_at(m_gidx));
		end
		g = goal_at(m_gidx);
		tgt_dist = int_sqrt(64'(dsq)) >> 8;
		if (tgt_dist > 64'd65535) tgt_dist = 64'd65535;
		r.px = m_x; r.py = m_y; r.hd = m_head; r.lu = m_lin; r.au = m_ang;
		r.tx = g[31:16]; r.ty = g[15:0]; r.td = tgt_dist[15:0];
		r.rch = hit; r.tc = m_ticks;
		m_ticks = m_ticks + 32'd1;
	endtask

	// Bench state follows register writes and accepted tick beats.
	always @(posedge clk) begin
		tick_t t;
		pose_t r;
		in_hs = in_valid && in_ready;
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				upi_pkg::REG_GOAL_A: m_goal[0] = cfg_data;
				upi_pkg::REG_GOAL_B: m_goal[1] = cfg_data;
				upi_pkg::REG_GOAL_C: m_goal[2] = cfg_data;
				upi_pkg::REG_OBST_C: m_obst = cfg_data;
				upi_pkg::REG_OBST_R: m_obst_r = cfg_data[15:0];
				upi_pkg::REG_GOAL_R: m_goal_r = cfg_data[15:0];
				upi_pkg::REG_STEP:   m_step = cfg_data[15:0];
				default: ;
			endcase
		end
		if (in_hs) begin
			t.cmd = cmd_present; t.lost = link_lost; t.lin = lin_vel; t.ang = ang_vel;
			integrate_tick(t, r);
			pose_q.push_back(r);
		end
	end

	// Driver: offers the next queued tick, idling at random, and stalls out_ready at random.
	always @(negedge clk) begin
		tick_t t;
		if (running && (!in_valid || in_hs)) begin
			if (tick_q.size() > 0 && !hold_send && !(idle_en && $urandom_range(99) < 36)) begin
				t = tick_q.pop_front();
				in_valid <= 1'b1;
				cmd_present <= t.cmd;
				link_lost <= t.lost;
				lin_vel <= t.lin;
				ang_vel <= t.ang;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= running && !(idle_en && $urandom_range(99) < 36);
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	// Monitor: compares each result beat with the oldest predicted pose.
	always @(posedge clk) begin
		pose_t e;
		if (out_valid && out_ready) begin
			if (pose_q.size() == 0) begin
				$display("%0t: result beat with no pose pending, actual tick %h",
					$time, tick_count);
				errors++;
			end else begin
				e = pose_q.pop_front();
				check_field("pos_x", e.px, pos_x);
				check_field("pos_y", e.py, pos_y);
				check_field("heading_angle", e.hd, heading_angle);
				check_field("lin_vel_used", e.lu, lin_vel_used);
				check_field("ang_vel_used", e.au, ang_vel_used);
				check_field("target_x", e.tx, target_x);
				check_field("target_y", e.ty, target_y);
				check_field("target_dist", e.td, target_dist);
				check_field("reached", e.rch, reached);
				check_field("collision", e.col, collision);
				check_field("tick_count", e.tc, tick_count);
			end
		end
	end

	task automatic write_reg(upi_pkg::reg_idx_t idx, logic [31:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all(logic [31:0] ga, logic [31:0] gb, logic [31:0] gc,
			logic [31:0] oc, logic [15:0] orad, logic [15:0] grad, logic [15:0] st);
		write_reg(upi_pkg::REG_GOAL_A, ga);
		write_reg(upi_pkg::REG_GOAL_B, gb);
		write_reg(upi_pkg::REG_GOAL_C, gc);
		write_reg(upi_pkg::REG_OBST_C, oc);
		write_reg(upi_pkg::REG_OBST_R, {16'h0, orad});
		write_reg(upi_pkg::REG_GOAL_R, {16'h0, grad});
		write_reg(upi_pkg::REG_STEP, {16'h0, st});
	endtask

	task automatic add_tick(bit c, bit l, logic [15:0] lv, logic [15:0] av);
		tick_t t;
		t.cmd = c; t.lost = l; t.lin = lv; t.ang = av;
		tick_q.push_back(t);
	endtask

	// Mostly fresh commands with modest speeds, some full-range noise and drops.
	task automatic add_random(int n);
		logic [15:0] lv, av;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(3) == 0) begin
				lv = 16'($urandom); av = 16'($urandom);
			end else begin
				lv = 16'($signed($urandom_range(8192)) - 4096);
				av = 16'($signed($urandom_range(12000)) - 6000);
			end
			add_tick($urandom_range(99) < 70, $urandom_range(99) < 8, lv, av);
		end
	endtask

	task automatic drain();
		while (tick_q.size() != 0 || in_valid || pose_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic logic [31:0] near_point();
		return {16'($signed($urandom_range(2048)) - 1024),
			16'($signed($urandom_range(2048)) - 1024)};
	endfunction

	initial begin
		m_goal[0] = 32'd50332160; m_goal[1] = 32'd4261413248; m_goal[2] = 32'd16842112;
		m_obst = 32'd25166080; m_obst_r = 16'd90; m_goal_r = 16'd51; m_step = 16'd655;
		m_x = '0; m_y = '0; m_ticks = '0; m_head = '0; m_lin = '0; m_ang = '0;
		m_gidx = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		running = 1;

		// Directed ticks at the reset settings.
		add_tick(0, 0, 16'h0000, 16'h0000);
		add_tick(1, 0, 16'h7FFF, 16'h0000);
		add_tick(0, 0, 16'h1234, 16'h4321);
		add_tick(1, 0, 16'h8000, 16'h7FFF);
		add_tick(0, 0, 16'h0000, 16'h0000);
		add_tick(1, 0, 16'h7FFF, 16'h8000);
		add_tick(1, 1, 16'h7FFF, 16'h7FFF);
		add_tick(0, 1, 16'h1111, 16'h2222);
		add_tick(1, 0, 16'h1000, 16'h0000);
		add_tick(0, 0, 16'hFFFF, 16'hFFFF);
		add_tick(1, 0, 16'hFFFF, 16'h0001);
		add_tick(1, 0, 16'h4000, 16'h7FFF);
		repeat (4) add_tick(0, 0, 16'h0000, 16'h0000);
		drain();

		// Extreme radii, step and corner goals: reached and collision every tick.
		write_all(32'h80008000, 32'h7FFF7FFF, 32'h7FFF8000, 32'h80007FFF,
			16'hFFFF, 16'hFFFF, 16'hFFFF);
		add_tick(1, 0, 16'h7FFF, 16'h7FFF);
		repeat (5) add_tick(0, 0, 16'h0000, 16'h0000);
		add_tick(1, 0, 16'h8000, 16'h8000);
		repeat (3) add_tick(0, 0, 16'h0000, 16'h0000);
		drain();

		// Zero radii and the smallest step; no idling in this stretch.
		idle_en = 0;
		write_all(32'h00000000, 32'hFFFFFFFF, 32'h00010001, 32'h00000000,
			16'h0000, 16'h0000, 16'h0001);
		add_random(60);
		drain();
		idle_en = 1;

		// Goals near the origin with wide discs so the goals cycle.
		write_all(near_point(), near_point(), near_point(), near_point(),
			16'h0200, 16'h0300, 16'd655);
		add_random(60);
		wait (tick_q.size() < 30);
		hold_send = 1;
		while (pose_q.size() != 0 || in_valid) @(posedge clk);
		hold_send = 0;
		drain();

		// Random settings.
		for (int p = 0; p < 5; p++) begin
			write_all($urandom, near_point(), near_point(), $urandom,
				16'($urandom_range(2048)), 16'($urandom_range(1024)),
				16'($urandom_range(65535, 1)));
			add_random(60);
			drain();
		end

		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
